>>> design/y2rgb_pkg.sv
// ----------------------------------------------------------------------------
// y2rgb_pkg: shared definitions for the YUV to RGB565 rotator
// Register codes, rotation codes, reset values and BT.601 coefficients.
// ----------------------------------------------------------------------------
package y2rgb_pkg;

	// Width of the frame size registers
	localparam int DIM_W = 11;

	// Default maximum frame size
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// Register reset values
	localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 11'd320;
	localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 11'd240;

	// Register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_ROTATION   = 2'd2,
		REG_BYTE_SWAP  = 2'd3
	} reg_idx_t;

	// Rotation codes
	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	// Channel sums fit in 19 signed bits
	localparam int SUM_W = 19;

	localparam logic signed [SUM_W-1:0] C_Y    = 19'sd298;
	localparam logic signed [SUM_W-1:0] C_RV   = 19'sd409;
	localparam logic signed [SUM_W-1:0] C_GU   = 19'sd100;
	localparam logic signed [SUM_W-1:0] C_GV   = 19'sd208;
	localparam logic signed [SUM_W-1:0] C_BU   = 19'sd516;
	localparam logic signed [SUM_W-1:0] C_RND  = 19'sd128;
	localparam logic [7:0]              Y_OFS  = 8'd16;
	localparam logic signed [9:0]       UV_OFS = 10'sd128;

endpackage

>>> design/y2rgb_color.sv
// ----------------------------------------------------------------------------
// y2rgb_color: BT.601 limited-range YUV to RGB565 pixel conversion
// Combinational: offset removal, three channel sums, clamp, pack, byte swap.
// ----------------------------------------------------------------------------
module y2rgb_color (
	input  logic [7:0]  y_sample,
	input  logic [7:0]  u_sample,
	input  logic [7:0]  v_sample,
	input  logic        byte_swap,
	output logic [15:0] pixel_rgb565
);
	import y2rgb_pkg::*;

	logic [7:0]              lum;
	logic signed [9:0]       cu;
	logic signed [9:0]       cv;
	logic signed [SUM_W-1:0] lum_s;
	logic signed [SUM_W-1:0] cu_s;
	logic signed [SUM_W-1:0] cv_s;
	logic signed [SUM_W-1:0] sum_r;
	logic signed [SUM_W-1:0] sum_g;
	logic signed [SUM_W-1:0] sum_b;
	logic [7:0]              r;
	logic [7:0]              g;
	logic [7:0]              b;
	logic [15:0]             packed_px;

	// Drop negatives to zero, saturate above 255, else keep sum/256
	function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] s);
		logic [7:0] res;
		if (s[SUM_W-1]) begin
			res = 8'd0;
		end else if (s[SUM_W-2:16] != '0) begin
			res = 8'hFF;
		end else begin
			res = s[15:8];
		end
		return res;
	endfunction

	assign lum   = (y_sample < Y_OFS) ? 8'd0 : (y_sample - Y_OFS);
	assign cu    = $signed({2'b00, u_sample}) - UV_OFS;
	assign cv    = $signed({2'b00, v_sample}) - UV_OFS;
	assign lum_s = $signed({{(SUM_W-8){1'b0}}, lum});
	assign cu_s  = {{(SUM_W-10){cu[9]}}, cu};
	assign cv_s  = {{(SUM_W-10){cv[9]}}, cv};

	assign sum_r = C_Y * lum_s + C_RV * cv_s + C_RND;
	assign sum_g = C_Y * lum_s - C_GU * cu_s - C_GV * cv_s + C_RND;
	assign sum_b = C_Y * lum_s + C_BU * cu_s + C_RND;

	assign r = clamp8(sum_r);
	assign g = clamp8(sum_g);
	assign b = clamp8(sum_b);

	assign packed_px    = {r[7:3], g[7:2], b[7:3]};
	assign pixel_rgb565 = byte_swap ? {packed_px[7:0], packed_px[15:8]} : packed_px;

endmodule

>>> design/yuv_to_rgb565_rotate.sv
// ----------------------------------------------------------------------------
// yuv_to_rgb565_rotate: YUV pixel to RGB565 converter with frame rotation
// Converts one source pixel per clock and maps its coordinates into the
// rotated destination frame.
// ----------------------------------------------------------------------------
// Throughput is one pixel per clock: start may be held high every cycle and
// busy never rises. Each request goes through one input register and one
// result register, in that order; its result then sits on the result ports,
// marked by done. The receiver cannot stall the stream; it must take every
// result as it comes. The single stage between the two registers holds the
// color conversion (constant-coefficient sums) and the one 11x11 multiply
// for dest_index, which sets the clock budget. Write the size, rotation and
// swap registers only while no request is in flight.
// ----------------------------------------------------------------------------
module yuv_to_rgb565_rotate #(
	parameter int MAX_WIDTH  = y2rgb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = y2rgb_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  y_sample,
	input  logic [7:0]  u_sample,
	input  logic [7:0]  v_sample,
	input  logic [9:0]  src_x,
	input  logic [9:0]  src_y,
	// result
	output logic        done,
	output logic [15:0] pixel_rgb565,
	output logic [9:0]  dest_x,
	output logic [9:0]  dest_y,
	output logic [19:0] dest_index,
	output logic        coord_error
);
	import y2rgb_pkg::*;

	// Size caps; a cap beyond what the register can hold never bites
	localparam int DIM_MAXV = (1 << DIM_W) - 1;
	localparam int W_LIM    = (MAX_WIDTH  > DIM_MAXV) ? DIM_MAXV : MAX_WIDTH;
	localparam int H_LIM    = (MAX_HEIGHT > DIM_MAXV) ? DIM_MAXV : MAX_HEIGHT;
	localparam logic [DIM_W-1:0] W_CAP = DIM_W'(W_LIM);
	localparam logic [DIM_W-1:0] H_CAP = DIM_W'(H_LIM);

	// Configuration registers
	logic [DIM_W-1:0] src_width_q;
	logic [DIM_W-1:0] src_height_q;
	rot_t             rotation_q;
	logic             byte_swap_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;

	// Input stage
	logic       valid_s1;
	logic [7:0] y_s1;
	logic [7:0] u_s1;
	logic [7:0] v_s1;
	logic [9:0] x_s1;
	logic [9:0] yc_s1;

	// Stage logic
	logic [DIM_W-1:0]   w_eff;
	logic [DIM_W-1:0]   h_eff;
	logic [DIM_W-1:0]   sx;
	logic [DIM_W-1:0]   sy;
	logic [DIM_W-1:0]   dx;
	logic [DIM_W-1:0]   dy;
	logic [DIM_W-1:0]   ow;
	logic [2*DIM_W-1:0] prod;
	logic [19:0]        idx;
	logic               err;
	logic [15:0]        pixel;

	// Result stage
	logic        valid_s2;
	logic [15:0] pixel_s2;
	logic [9:0]  dx_s2;
	logic [9:0]  dy_s2;
	logic [19:0] idx_s2;
	logic        err_s2;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= RST_SRC_WIDTH;
			src_height_q <= RST_SRC_HEIGHT;
			rotation_q   <= ROT_0;
			byte_swap_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_SRC_WIDTH:  src_width_q  <= pwdata[DIM_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= pwdata[DIM_W-1:0];
				REG_ROTATION:   rotation_q   <= rot_t'(pwdata[1:0]);
				REG_BYTE_SWAP:  byte_swap_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register, zero-extended
	always_comb begin
		case (cfg_idx)
			REG_SRC_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, src_width_q};
			REG_SRC_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, src_height_q};
			REG_ROTATION:   prdata = {30'd0, rotation_q};
			REG_BYTE_SWAP:  prdata = {31'd0, byte_swap_q};
			default:        prdata = 32'd0;
		endcase
	end

	// ---------------- input register ----------------
	// Never stall: accept a request in every cycle
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// Payload needs no reset; capture only on an accepted request
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			y_s1  <= y_sample;
			u_s1  <= u_sample;
			v_s1  <= v_sample;
			x_s1  <= src_x;
			yc_s1 <= src_y;
		end
	end

	// ---------------- conversion stage ----------------
	y2rgb_color u_color (
		.y_sample     (y_s1),
		.u_sample     (u_s1),
		.v_sample     (v_s1),
		.byte_swap    (byte_swap_q),
		.pixel_rgb565 (pixel)
	);

	// Clip oversized frames to the build-time maximum
	assign w_eff = (src_width_q  > W_CAP) ? W_CAP : src_width_q;
	assign h_eff = (src_height_q > H_CAP) ? H_CAP : src_height_q;
	assign sx    = {1'b0, x_s1};
	assign sy    = {1'b0, yc_s1};
	assign err   = (sx >= w_eff) || (sy >= h_eff);

	// Rotate coordinates; the output row length follows the rotation
	always_comb begin
		case (rotation_q)
			ROT_90: begin
				dx = h_eff - 1'b1 - sy;
				dy = sx;
				ow = h_eff;
			end
			ROT_180: begin
				dx = w_eff - 1'b1 - sx;
				dy = h_eff - 1'b1 - sy;
				ow = w_eff;
			end
			ROT_270: begin
				dx = sy;
				dy = w_eff - 1'b1 - sx;
				ow = h_eff;
			end
			default: begin
				dx = sx;
				dy = sy;
				ow = w_eff;
			end
		endcase
	end

	assign prod = dy * ow;
	assign idx  = 20'(prod + {{DIM_W{1'b0}}, dx});

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Out-of-frame pixels still convert, but drop their coordinates to zero
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pixel_s2 <= pixel;
			err_s2   <= err;
			dx_s2    <= err ? 10'd0 : dx[9:0];
			dy_s2    <= err ? 10'd0 : dy[9:0];
			idx_s2   <= err ? 20'd0 : idx;
		end
	end

	assign done         = valid_s2;
	assign pixel_rgb565 = pixel_s2;
	assign dest_x       = dx_s2;
	assign dest_y       = dy_s2;
	assign dest_index   = idx_s2;
	assign coord_error  = err_s2;

endmodule

>>> design/y2rgb_checker.sv
// ----------------------------------------------------------------------------
// y2rgb_checker: port-level checks for yuv_to_rgb565_rotate
// Watches request-to-result timing, the out-of-frame result fields and pready.
// ----------------------------------------------------------------------------
module y2rgb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [9:0]  dest_x,
	input logic [9:0]  dest_y,
	input logic [19:0] dest_index,
	input logic        coord_error
);

	// Every accepted request yields a result after the input and result registers
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted request produced no result");

	// No result without a matching accepted request before it
	a_done_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a matching request");

	// Out-of-frame results carry zero coordinates
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && coord_error) |-> (dest_x == 10'd0 && dest_y == 10'd0 &&
		dest_index == 20'd0))
		else $error("out-of-frame result with nonzero coordinates");

	// Configuration port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind yuv_to_rgb565_rotate y2rgb_checker u_checker (.*);
